FILE: rtl/core/spc_pkg.sv
// Shared constants, command codes, control structs and helper functions of the shuffle player.
package spc_pkg;

    // Default library depth.
    localparam int MAX_TRACKS_DEF = 1024;

    // Field widths.
    localparam int IDX_W      = 10;
    localparam int OP_W       = 3;
    localparam int FID_W      = 16;
    localparam int SIZE_W     = 11;
    localparam int VREQ_W     = 16;
    localparam int VOL_W      = 8;
    localparam int RNG_W      = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;
    localparam int S_TDATA_W  = 56;
    localparam int M_TDATA_W  = 40;

    // Register reset values.
    localparam logic [VOL_W-1:0] MAX_VOL_RST  = 8'd21;
    localparam logic [VOL_W-1:0] INIT_VOL_RST = 8'd12;
    localparam logic [RNG_W-1:0] SEED_RST     = 32'd2463534242;

    // Operation codes.
    localparam logic [OP_W-1:0] OP_PLAY   = 3'd0;
    localparam logic [OP_W-1:0] OP_TOGGLE = 3'd1;
    localparam logic [OP_W-1:0] OP_PAUSE  = 3'd2;
    localparam logic [OP_W-1:0] OP_NEXT   = 3'd3;
    localparam logic [OP_W-1:0] OP_PREV   = 3'd4;
    localparam logic [OP_W-1:0] OP_VOLUME = 3'd5;
    localparam logic [OP_W-1:0] OP_STOP   = 3'd6;
    localparam logic [OP_W-1:0] OP_EOT    = 3'd7;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_VOL  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INIT_VOL = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SEED     = 2'd2;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic latch_in;
        logic play_setup;
        logic fill_init;
        logic fill_step;
        logic shuf_init;
        logic mdiv_start;
        logic limit_cap;
        logic rng_step;
        logic rdiv_start;
        logic j_cap;
        logic rd_j;
        logic rd_i;
        logic wr_i;
        logic wr_j;
        logic begin_play;
        logic pos_inc;
        logic pos_dec;
        logic toggle;
        logic pause;
        logic vol_set;
        logic stop;
        logic out_load;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            size_zero;
        logic            loaded;
        logic            paused;
        logic            qlen_zero;
        logic            pos_last;
        logic            fill_done;
        logic            shuf_done;
        logic            div_done;
        logic            reject;
    } stat_t;

    // One step of the xorshift32 generator.
    function automatic logic [RNG_W-1:0] xorshift32(input logic [RNG_W-1:0] x);
        logic [RNG_W-1:0] y;
        y = x ^ (x << 13);
        y = y ^ (y >> 17);
        y = y ^ (y << 5);
        return y;
    endfunction

    // A zero seed falls back to the reset seed.
    function automatic logic [RNG_W-1:0] fix_seed(input logic [RNG_W-1:0] s);
        return (s == '0) ? SEED_RST : s;
    endfunction

endpackage

FILE: rtl/core/spc_ram.sv
// Generic single-write, single-read RAM with registered read data.
module spc_ram #(
    parameter int WIDTH = 10,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/core/spc_mod.sv
// Bit-serial restoring remainder unit: 32-bit dividend modulo a narrow divisor.
module spc_mod #(
    parameter int DW = 11
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [31:0]   dividend,
    input  logic [DW-1:0] divisor,
    output logic          done,
    output logic [DW-1:0] rem
);

    logic [DW-1:0] rem_reg, rem_next;
    logic [31:0]   dvd_reg, dvd_next;
    logic [DW-1:0] dsr_reg, dsr_next;
    logic [5:0]    cnt_reg, cnt_next;
    logic          done_reg, done_next;
    logic [DW:0]   trial;
    logic [DW:0]   diff;

    // One dividend bit enters the partial remainder each cycle.
    always_comb
    begin
        trial     = {rem_reg, dvd_reg[31]};
        diff      = trial - {1'b0, dsr_reg};
        rem_next  = rem_reg;
        dvd_next  = dvd_reg;
        dsr_next  = dsr_reg;
        cnt_next  = cnt_reg;
        done_next = done_reg;
        if (start)
        begin
            rem_next  = '0;
            dvd_next  = dividend;
            dsr_next  = divisor;
            cnt_next  = 6'd32;
            done_next = 1'b0;
        end
        else if (cnt_reg != '0)
        begin
            rem_next = (trial >= {1'b0, dsr_reg}) ? diff[DW-1:0] : trial[DW-1:0];
            dvd_next = {dvd_reg[30:0], 1'b0};
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1)
            begin
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dvd_reg <= dvd_next;
        dsr_reg <= dsr_next;
    end

    assign done = done_reg;
    assign rem  = rem_reg;

endmodule

FILE: rtl/core/spc_datapath.sv
// Datapath: player state, order table, random source, remainder unit and result register.
module spc_datapath #(
    parameter int MAX_TRACKS = spc_pkg::MAX_TRACKS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  spc_pkg::cmd_t                 cmd,
    output spc_pkg::stat_t                stat,
    input  logic [spc_pkg::OP_W-1:0]      in_op,
    input  logic [spc_pkg::S_TDATA_W-1:0] in_data,
    input  logic                          cfg_we,
    input  logic [spc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [spc_pkg::CFG_DATA_W-1:0] cfg_data,
    output logic [spc_pkg::M_TDATA_W-1:0] out_data
);
    import spc_pkg::*;

    localparam int LW = $clog2(MAX_TRACKS + 1);
    localparam int PW = $clog2(MAX_TRACKS);

    // Latched command.
    logic [OP_W-1:0]   op_reg;
    logic [FID_W-1:0]  fid_reg;
    logic [IDX_W-1:0]  first_reg;
    logic [SIZE_W-1:0] size_reg;
    logic [VREQ_W-1:0] vreq_reg;

    // Player state.
    logic [LW-1:0]    qlen_reg, qlen_next;
    logic [PW-1:0]    pos_reg, pos_next;
    logic [IDX_W-1:0] base_reg, base_next;
    logic [LW-1:0]    count_reg, count_next;
    logic [FID_W-1:0] tag_reg, tag_next;
    logic             loaded_reg, loaded_next;
    logic             playing_reg, playing_next;
    logic             paused_reg, paused_next;
    logic [VOL_W-1:0] vol_reg, vol_next;
    logic [VOL_W-1:0] maxvol_reg, maxvol_next;
    logic [RNG_W-1:0] rng_reg, rng_next;
    logic             start_reg, start_next;
    logic             flip_reg, flip_next;
    logic             stop_reg, stop_next;

    // Shuffle working registers.
    logic [LW-1:0]    i_reg, i_next;
    logic [PW-1:0]    j_reg, j_next;
    logic [31:0]      limit_reg, limit_next;
    logic [31:0]      r_reg, r_next;
    logic [IDX_W-1:0] tj_reg, tj_next;
    logic [IDX_W-1:0] ti_reg, ti_next;
    logic [M_TDATA_W-1:0] out_reg, out_next;

    // Memory and remainder unit signals.
    logic             ram_we;
    logic [PW-1:0]    ram_waddr, ram_raddr;
    logic [IDX_W-1:0] ram_wdata, ram_rdata;
    logic [LW-1:0]    mod_rem;
    logic             mod_done;
    logic [PW-1:0]    i_less;
    logic [31:0]      size_sat;

    assign i_less   = PW'(i_reg - LW'(1));
    assign size_sat = (32'(size_reg) > 32'(MAX_TRACKS)) ? 32'(MAX_TRACKS) : 32'(size_reg);

    spc_ram #(
        .WIDTH (IDX_W),
        .DEPTH (MAX_TRACKS)
    ) u_order (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    spc_mod #(
        .DW (LW)
    ) u_mod (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.mdiv_start | cmd.rdiv_start),
        .dividend (cmd.mdiv_start ? 32'hFFFF_FFFF : r_reg),
        .divisor  (i_reg),
        .done     (mod_done),
        .rem      (mod_rem)
    );

    // Order table port selection.
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = i_reg[PW-1:0];
        ram_wdata = IDX_W'(32'(base_reg) + 32'(i_reg));
        if (cmd.fill_step)
        begin
            ram_we = 1'b1;
        end
        else if (cmd.wr_i)
        begin
            ram_we    = 1'b1;
            ram_waddr = i_less;
            ram_wdata = tj_reg;
        end
        else if (cmd.wr_j)
        begin
            ram_we    = 1'b1;
            ram_waddr = j_reg;
            ram_wdata = ti_reg;
        end
        if (cmd.rd_j)
        begin
            ram_raddr = j_reg;
        end
        else if (cmd.rd_i)
        begin
            ram_raddr = i_less;
        end
        else
        begin
            ram_raddr = pos_reg;
        end
    end

    // Next-state logic of the player and shuffle registers.
    always_comb
    begin
        qlen_next    = qlen_reg;
        pos_next     = pos_reg;
        base_next    = base_reg;
        count_next   = count_reg;
        tag_next     = tag_reg;
        loaded_next  = loaded_reg;
        playing_next = playing_reg;
        paused_next  = paused_reg;
        vol_next     = vol_reg;
        maxvol_next  = maxvol_reg;
        rng_next     = rng_reg;
        start_next   = start_reg;
        flip_next    = flip_reg;
        stop_next    = stop_reg;
        i_next       = i_reg;
        j_next       = j_reg;
        limit_next   = limit_reg;
        r_next       = r_reg;
        tj_next      = tj_reg;
        ti_next      = ti_reg;
        out_next     = out_reg;

        if (cfg_we)
        begin
            case (cfg_index)
                CFG_MAX_VOL:  maxvol_next = cfg_data[VOL_W-1:0];
                CFG_INIT_VOL: vol_next    = cfg_data[VOL_W-1:0];
                CFG_SEED:     rng_next    = fix_seed(cfg_data[RNG_W-1:0]);
                default:      ;
            endcase
        end

        if (cmd.latch_in)
        begin
            start_next = 1'b0;
            flip_next  = 1'b0;
            stop_next  = 1'b0;
        end
        if (cmd.play_setup)
        begin
            tag_next   = fid_reg;
            base_next  = first_reg;
            count_next = LW'(size_sat);
        end
        if (cmd.fill_init)
        begin
            qlen_next = count_reg;
            pos_next  = '0;
            i_next    = '0;
        end
        if (cmd.fill_step)
        begin
            i_next = i_reg + LW'(1);
        end
        if (cmd.shuf_init)
        begin
            i_next = count_reg;
        end
        if (cmd.limit_cap)
        begin
            limit_next = 32'hFFFF_FFFF - 32'(mod_rem);
        end
        if (cmd.rng_step)
        begin
            rng_next = xorshift32(rng_reg);
            r_next   = xorshift32(rng_reg);
        end
        if (cmd.j_cap)
        begin
            j_next = PW'(mod_rem);
        end
        if (cmd.rd_i)
        begin
            tj_next = ram_rdata;
        end
        if (cmd.wr_i)
        begin
            ti_next = ram_rdata;
        end
        if (cmd.wr_j)
        begin
            i_next = i_reg - LW'(1);
        end
        if (cmd.pos_inc)
        begin
            pos_next = pos_reg + PW'(1);
        end
        if (cmd.pos_dec && pos_reg != '0)
        begin
            pos_next = pos_reg - PW'(1);
        end
        if (cmd.begin_play)
        begin
            loaded_next  = 1'b1;
            playing_next = 1'b1;
            paused_next  = 1'b0;
            start_next   = 1'b1;
        end
        if (cmd.toggle)
        begin
            flip_next    = 1'b1;
            paused_next  = !paused_reg;
            playing_next = paused_reg;
        end
        if (cmd.pause)
        begin
            flip_next    = 1'b1;
            paused_next  = 1'b1;
            playing_next = 1'b0;
        end
        if (cmd.vol_set)
        begin
            vol_next = (vreq_reg > VREQ_W'(maxvol_reg)) ? maxvol_reg : vreq_reg[VOL_W-1:0];
        end
        if (cmd.stop)
        begin
            stop_next    = 1'b1;
            loaded_next  = 1'b0;
            playing_next = 1'b0;
            paused_next  = 1'b0;
            qlen_next    = '0;
        end
        if (cmd.out_load)
        begin
            out_next = {stop_reg, flip_reg, start_reg, tag_reg, vol_reg, paused_reg,
                        playing_reg, loaded_reg,
                        (qlen_reg != '0) ? ram_rdata : {IDX_W{1'b0}}};
        end
    end

    // Control-relevant state with reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            qlen_reg    <= '0;
            pos_reg     <= '0;
            base_reg    <= '0;
            count_reg   <= '0;
            tag_reg     <= '0;
            loaded_reg  <= 1'b0;
            playing_reg <= 1'b0;
            paused_reg  <= 1'b0;
            vol_reg     <= INIT_VOL_RST;
            maxvol_reg  <= MAX_VOL_RST;
            rng_reg     <= SEED_RST;
            start_reg   <= 1'b0;
            flip_reg    <= 1'b0;
            stop_reg    <= 1'b0;
            i_reg       <= '0;
        end
        else
        begin
            qlen_reg    <= qlen_next;
            pos_reg     <= pos_next;
            base_reg    <= base_next;
            count_reg   <= count_next;
            tag_reg     <= tag_next;
            loaded_reg  <= loaded_next;
            playing_reg <= playing_next;
            paused_reg  <= paused_next;
            vol_reg     <= vol_next;
            maxvol_reg  <= maxvol_next;
            rng_reg     <= rng_next;
            start_reg   <= start_next;
            flip_reg    <= flip_next;
            stop_reg    <= stop_next;
            i_reg       <= i_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (cmd.latch_in)
        begin
            op_reg    <= in_op;
            fid_reg   <= in_data[15:0];
            first_reg <= in_data[25:16];
            size_reg  <= in_data[36:26];
            vreq_reg  <= in_data[52:37];
        end
        j_reg     <= j_next;
        limit_reg <= limit_next;
        r_reg     <= r_next;
        tj_reg    <= tj_next;
        ti_reg    <= ti_next;
        out_reg   <= out_next;
    end

    // Status towards the controller.
    always_comb
    begin
        stat.op        = op_reg;
        stat.size_zero = (size_reg == '0);
        stat.loaded    = loaded_reg;
        stat.paused    = paused_reg;
        stat.qlen_zero = (qlen_reg == '0);
        stat.pos_last  = (32'(pos_reg) + 32'd1 >= 32'(qlen_reg));
        stat.fill_done = (i_reg == count_reg);
        stat.shuf_done = (i_reg <= LW'(1));
        stat.div_done  = mod_done;
        stat.reject    = (r_reg >= limit_reg);
    end

    assign out_data = out_reg;

endmodule

FILE: rtl/core/spc_ctrl.sv
// Controller state machine: sequences command decode, table fill, shuffle swaps and result output.
module spc_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           s_tvalid,
    output logic           s_tready,
    output logic           m_tvalid,
    input  logic           m_tready,
    input  spc_pkg::stat_t stat,
    output spc_pkg::cmd_t  cmd
);
    import spc_pkg::*;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_DECODE = 4'd1;
    localparam logic [3:0] S_FILLI  = 4'd2;
    localparam logic [3:0] S_FILL   = 4'd3;
    localparam logic [3:0] S_SHUF   = 4'd4;
    localparam logic [3:0] S_MSTART = 4'd5;
    localparam logic [3:0] S_MWAIT  = 4'd6;
    localparam logic [3:0] S_RSTEP  = 4'd7;
    localparam logic [3:0] S_RCHK   = 4'd8;
    localparam logic [3:0] S_RWAIT  = 4'd9;
    localparam logic [3:0] S_RDJ    = 4'd10;
    localparam logic [3:0] S_RDI    = 4'd11;
    localparam logic [3:0] S_WRI    = 4'd12;
    localparam logic [3:0] S_WRJ    = 4'd13;
    localparam logic [3:0] S_LOOK   = 4'd14;
    localparam logic [3:0] S_DONE   = 4'd15;

    logic [3:0] state_reg, state_next;
    logic       valid_reg, valid_next;

    // State transitions and command generation.
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.latch_in = 1'b1;
                    state_next   = S_DECODE;
                end
            end
            S_DECODE:
            begin
                state_next = S_LOOK;
                case (stat.op)
                    OP_PLAY:
                    begin
                        if (!stat.size_zero)
                        begin
                            cmd.play_setup = 1'b1;
                            state_next     = S_FILLI;
                        end
                    end
                    OP_TOGGLE: cmd.toggle = stat.loaded;
                    OP_PAUSE:  cmd.pause  = stat.loaded && !stat.paused;
                    OP_PREV:
                    begin
                        if (!stat.qlen_zero)
                        begin
                            cmd.pos_dec    = 1'b1;
                            cmd.begin_play = 1'b1;
                        end
                    end
                    OP_VOLUME: cmd.vol_set = 1'b1;
                    OP_STOP:   cmd.stop    = 1'b1;
                    default:
                    begin
                        // Next track and end of track step forward.
                        if (!stat.qlen_zero)
                        begin
                            if (stat.pos_last)
                            begin
                                state_next = S_FILLI;
                            end
                            else
                            begin
                                cmd.pos_inc    = 1'b1;
                                cmd.begin_play = 1'b1;
                            end
                        end
                    end
                endcase
            end
            S_FILLI:
            begin
                cmd.fill_init = 1'b1;
                state_next    = S_FILL;
            end
            S_FILL:
            begin
                if (stat.fill_done)
                begin
                    cmd.shuf_init = 1'b1;
                    state_next    = S_SHUF;
                end
                else
                begin
                    cmd.fill_step = 1'b1;
                end
            end
            S_SHUF:
            begin
                if (stat.shuf_done)
                begin
                    cmd.begin_play = 1'b1;
                    state_next     = S_LOOK;
                end
                else
                begin
                    state_next = S_MSTART;
                end
            end
            S_MSTART:
            begin
                cmd.mdiv_start = 1'b1;
                state_next     = S_MWAIT;
            end
            S_MWAIT:
            begin
                if (stat.div_done)
                begin
                    cmd.limit_cap = 1'b1;
                    state_next    = S_RSTEP;
                end
            end
            S_RSTEP:
            begin
                cmd.rng_step = 1'b1;
                state_next   = S_RCHK;
            end
            S_RCHK:
            begin
                if (stat.reject)
                begin
                    state_next = S_RSTEP;
                end
                else
                begin
                    cmd.rdiv_start = 1'b1;
                    state_next     = S_RWAIT;
                end
            end
            S_RWAIT:
            begin
                if (stat.div_done)
                begin
                    cmd.j_cap  = 1'b1;
                    state_next = S_RDJ;
                end
            end
            S_RDJ:
            begin
                cmd.rd_j   = 1'b1;
                state_next = S_RDI;
            end
            S_RDI:
            begin
                cmd.rd_i   = 1'b1;
                state_next = S_WRI;
            end
            S_WRI:
            begin
                cmd.wr_i   = 1'b1;
                state_next = S_WRJ;
            end
            S_WRJ:
            begin
                cmd.wr_j   = 1'b1;
                state_next = S_SHUF;
            end
            S_LOOK:
            begin
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!valid_reg || m_tready)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // The result register holds until the transaction completes.
    always_comb
    begin
        valid_next = valid_reg;
        if (cmd.out_load)
        begin
            valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= valid_next;
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = valid_reg;

endmodule

FILE: rtl/core/shuffle_playlist_controller.sv
// Top level of the shuffle player: one command in, one status transaction out.
// A simple command goes through decode and lookup to the result register; one command is
// in work at a time, so a new command is accepted only once the last result is loaded.
// Play folder and a wrapping next also fill the order table and, per element from N down to 2,
// run two remainder operations, a redraw per rejected draw and a swap of two table entries.
// Reset (rst_n, asynchronous) empties the queue, clears the flags and reloads the register
// defaults.
module shuffle_playlist_controller #(
    parameter int MAX_TRACKS = spc_pkg::MAX_TRACKS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // folder_id[15:0], folder_first[25:16], folder_size[36:26], volume_request[52:37]
    input  logic [spc_pkg::S_TDATA_W-1:0]  s_tdata,
    // operation[2:0]
    input  logic [spc_pkg::OP_W-1:0]       s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // track_index[9:0], has_track[10], is_playing[11], is_paused[12], volume_level[20:13],
    // current_folder_id[36:21], start_pulse[37], pause_resume_pulse[38], stop_pulse[39]
    output logic [spc_pkg::M_TDATA_W-1:0]  m_tdata,
    input  logic                           cfg_we,
    input  logic [spc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [spc_pkg::CFG_DATA_W-1:0] cfg_data
);
    import spc_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    spc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    spc_datapath #(
        .MAX_TRACKS (MAX_TRACKS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .in_op     (s_tuser),
        .in_data   (s_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .out_data  (m_tdata)
    );

endmodule

FILE: rtl/core/spc_checker.sv
// Port-level checks of the shuffle player and their binding to the top level.
module spc_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [39:0] m_tdata
);

    // A stalled result holds.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    // One command at a time: no acceptance right after an acceptance.
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted while a command is in work");

    // Stop leaves no track loaded and no flag set.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[39] |-> m_tdata[12:10] == 3'b000)
        else $error("stop left flags set");

    // Playing and paused never show together.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(m_tdata[11] && m_tdata[12]))
        else $error("playing and paused both set");

    // A start leaves a loaded, playing track.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[37] |-> m_tdata[11:10] == 2'b11)
        else $error("start without playing track");

endmodule

bind shuffle_playlist_controller spc_checker u_spc_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

FILE: tb/shuffle_playlist_checker.sv
// Status predictor and scoreboard for the shuffle player, watching its command, status and
// configuration ports.
module shuffle_playlist_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    input  logic [spc_pkg::S_TDATA_W-1:0]   s_tdata,
    input  logic [spc_pkg::OP_W-1:0]        s_tuser,
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic [spc_pkg::M_TDATA_W-1:0]   m_tdata,
    input  logic                            cfg_we,
    input  logic [spc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [spc_pkg::CFG_DATA_W-1:0]  cfg_data,
    output int                              fail_count,
    output int                              pending
);
    import spc_pkg::*;

    localparam int LIB_DEPTH = MAX_TRACKS_DEF;

    typedef struct packed {
        logic              stop_p;
        logic              flip_p;
        logic              start_p;
        logic [FID_W-1:0]  folder;
        logic [VOL_W-1:0]  volume;
        logic              paused;
        logic              playing;
        logic              loaded;
        logic [IDX_W-1:0]  track;
    } player_status_t;

    // Model copy of the player state and registers.
    logic [IDX_W-1:0]  play_order [LIB_DEPTH];
    int unsigned       order_len;
    int unsigned       order_pos;
    logic [IDX_W-1:0]  base_idx;
    int unsigned       track_count;
    logic [FID_W-1:0]  folder_tag;
    logic              loaded_q, playing_q, paused_q;
    logic [VOL_W-1:0]  volume_q;
    logic [RNG_W-1:0]  rand_word;
    logic [VOL_W-1:0]  vol_ceiling;
    logic [VOL_W-1:0]  vol_start;

    player_status_t    status_queue [$];

    // Unbiased draw in [0, bound) by rejection sampling.
    function automatic int unsigned draw_below(input int unsigned bound);
        logic [RNG_W-1:0] cutoff;
        logic [RNG_W-1:0] r;
        if (bound <= 1)
            return 0;
        cutoff = 32'hFFFF_FFFF - (32'hFFFF_FFFF % bound);
        do
        begin
            r = rand_word;
            r = r ^ (r << 13);
            r = r ^ (r >> 17);
            r = r ^ (r << 5);
            rand_word = r;
        end
        while (r >= cutoff);
        return r % bound;
    endfunction

    // Rebuild and shuffle the play order for the current folder.
    function automatic void shuffle_folder();
        int unsigned j;
        logic [IDX_W-1:0] t;
        order_len = track_count;
        for (int unsigned i = 0; i < track_count; i++)
            play_order[i] = base_idx + i[IDX_W-1:0];
        for (int unsigned i = track_count; i > 1; i--)
        begin
            j = draw_below(i);
            t = play_order[i-1];
            play_order[i-1] = play_order[j];
            play_order[j] = t;
        end
        order_pos = 0;
    endfunction

    function automatic logic start_track();
        if (order_len == 0)
            return 1'b0;
        loaded_q = 1'b1;
        playing_q = 1'b1;
        paused_q = 1'b0;
        return 1'b1;
    endfunction

    function automatic logic move_in_order(input logic forward);
        if (order_len == 0)
            return 1'b0;
        if (forward)
        begin
            order_pos++;
            if (order_pos >= order_len)
                shuffle_folder();
        end
        else if (order_pos > 0)
        begin
            order_pos--;
        end
        return start_track();
    endfunction

    // Apply one command and produce the status it should give.
    task automatic predict_status(input logic [OP_W-1:0] op, input logic [S_TDATA_W-1:0] d,
                                  output player_status_t st);
        logic [FID_W-1:0]  fid;
        logic [IDX_W-1:0]  first;
        int unsigned       size;
        logic [VREQ_W-1:0] req;
        logic              start, flip, stop;
        fid   = d[15:0];
        first = d[25:16];
        size  = d[36:26];
        req   = d[52:37];
        start = 1'b0;
        flip  = 1'b0;
        stop  = 1'b0;
        case (op)
            OP_PLAY:
            begin
                if (size != 0)
                begin
                    if (size > LIB_DEPTH)
                        size = LIB_DEPTH;
                    folder_tag  = fid;
                    base_idx    = first;
                    track_count = size;
                    shuffle_folder();
                    start = start_track();
                end
            end
            OP_TOGGLE:
            begin
                if (loaded_q)
                begin
                    flip = 1'b1;
                    paused_q = !paused_q;
                    playing_q = !paused_q;
                end
            end
            OP_PAUSE:
            begin
                if (loaded_q && !paused_q)
                begin
                    flip = 1'b1;
                    paused_q = 1'b1;
                    playing_q = 1'b0;
                end
            end
            OP_NEXT, OP_EOT: start = move_in_order(1'b1);
            OP_PREV:         start = move_in_order(1'b0);
            OP_VOLUME:       volume_q = (req > vol_ceiling) ? vol_ceiling : req[VOL_W-1:0];
            default:
            begin
                stop = 1'b1;
                loaded_q = 1'b0;
                playing_q = 1'b0;
                paused_q = 1'b0;
                order_len = 0;
            end
        endcase
        st.track   = (order_len != 0 && order_pos < LIB_DEPTH) ? play_order[order_pos] : '0;
        st.loaded  = loaded_q;
        st.playing = playing_q;
        st.paused  = paused_q;
        st.volume  = volume_q;
        st.folder  = folder_tag;
        st.start_p = start;
        st.flip_p  = flip;
        st.stop_p  = stop;
    endtask

    // Track configuration, predict accepted commands and compare returned status.
    always @(posedge clk or negedge rst_n)
    begin : scoreboard
        player_status_t st;
        player_status_t got;
        if (!rst_n)
        begin
            order_len   = 0;
            order_pos   = 0;
            base_idx    = '0;
            track_count = 0;
            folder_tag  = '0;
            loaded_q    = 1'b0;
            playing_q   = 1'b0;
            paused_q    = 1'b0;
            vol_ceiling = MAX_VOL_RST;
            vol_start   = INIT_VOL_RST;
            volume_q    = INIT_VOL_RST;
            rand_word   = SEED_RST;
            status_queue.delete();
            fail_count  = 0;
            pending     = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == CFG_MAX_VOL)
                    vol_ceiling = cfg_data[VOL_W-1:0];
                else if (cfg_index == CFG_INIT_VOL)
                begin
                    vol_start = cfg_data[VOL_W-1:0];
                    volume_q = vol_start;
                end
                else if (cfg_index == CFG_SEED)
                    rand_word = (cfg_data == '0) ? SEED_RST : cfg_data;
            end
            if (m_tvalid && m_tready)
            begin
                got = m_tdata;
                if (status_queue.size() == 0)
                begin
                    $display("%0t: status transaction with none expected: %h", $realtime, got);
                    fail_count++;
                end
                else
                begin
                    st = status_queue.pop_front();
                    if (got.track !== st.track || got.loaded !== st.loaded
                        || got.playing !== st.playing || got.paused !== st.paused
                        || got.volume !== st.volume || got.folder !== st.folder
                        || got.start_p !== st.start_p || got.flip_p !== st.flip_p
                        || got.stop_p !== st.stop_p)
                    begin
                        $display("%0t: status mismatch: expected %p, got %p",
                                 $realtime, st, got);
                        fail_count++;
                    end
                end
            end
            if (s_tvalid && s_tready)
            begin
                predict_status(s_tuser, s_tdata, st);
                status_queue.push_back(st);
            end
            pending = status_queue.size();
        end
    end

endmodule

FILE: tb/shuffle_playlist_controller_tb.sv
// Stimulus and verdict for the shuffle player: directed and random commands over several
// register settings and idling phases.
module shuffle_playlist_controller_tb;
    import spc_pkg::*;

    localparam int CYCLE_LIMIT = 3_000_000;

    logic                  clk;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata;
    logic [OP_W-1:0]       s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    int                    fail_count;
    int                    pending;
    int                    send_idle_pct;
    int                    recv_stall_pct;
    int unsigned           cycle_count;

    shuffle_playlist_controller uut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    shuffle_playlist_checker status_checker (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .fail_count(fail_count), .pending(pending)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    // Run-away guard.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Status receiver with random back-pressure.
    always @(posedge clk)
    begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Issue one command transaction, with random idle cycles before it.
    task automatic send_cmd(input logic [OP_W-1:0] op, input logic [FID_W-1:0] fid,
                            input logic [IDX_W-1:0] first, input logic [SIZE_W-1:0] size,
                            input logic [VREQ_W-1:0] vreq);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {3'b0, vreq, size, first, fid};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_regs(input logic [VOL_W-1:0] vmax, input logic [VOL_W-1:0] vinit,
                            input logic [RNG_W-1:0] seed);
        write_reg(CFG_MAX_VOL, CFG_DATA_W'(vmax));
        write_reg(CFG_INIT_VOL, CFG_DATA_W'(vinit));
        write_reg(CFG_SEED, CFG_DATA_W'(seed));
    endtask

    // Random commands: mostly plays of small folders and steps through them.
    task automatic random_cmds(input int count);
        logic [OP_W-1:0]   op;
        logic [SIZE_W-1:0] size;
        logic [VREQ_W-1:0] vreq;
        int                pick;
        for (int n = 0; n < count; n++)
        begin
            pick = $urandom_range(99);
            if (pick < 22)
                op = OP_PLAY;
            else if (pick < 42)
                op = OP_NEXT;
            else if (pick < 52)
                op = OP_EOT;
            else if (pick < 64)
                op = OP_PREV;
            else if (pick < 72)
                op = OP_TOGGLE;
            else if (pick < 80)
                op = OP_PAUSE;
            else if (pick < 92)
                op = OP_VOLUME;
            else
                op = OP_STOP;
            // Large folders are slow, so only a few of them.
            if ($urandom_range(49) == 0)
                size = SIZE_W'($urandom_range(2047));
            else
                size = SIZE_W'($urandom_range(9));
            vreq = $urandom_range(1) ? VREQ_W'($urandom_range(65535))
                                     : VREQ_W'($urandom_range(300));
            send_cmd(op, FID_W'($urandom_range(65535)), IDX_W'($urandom_range(1023)),
                     size, vreq);
        end
    endtask

    initial
    begin
        s_tvalid       <= 1'b0;
        s_tdata        <= '0;
        s_tuser        <= OP_STOP;
        m_tready       <= 1'b0;
        cfg_we         <= 1'b0;
        cfg_index      <= CFG_MAX_VOL;
        cfg_data       <= '0;
        cycle_count    <= 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        rst_n          <= 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty player, volume extremes, saturation of a full folder and wrap of small folders.
        send_cmd(OP_STOP,   16'h0000, 10'd0, 11'd0, 16'd0);
        send_cmd(OP_NEXT,   16'h0001, 10'd0, 11'd0, 16'd0);
        send_cmd(OP_PREV,   16'h0001, 10'd0, 11'd0, 16'd0);
        send_cmd(OP_EOT,    16'h0001, 10'd0, 11'd0, 16'd0);
        send_cmd(OP_TOGGLE, 16'h0001, 10'd0, 11'd0, 16'd0);
        send_cmd(OP_PAUSE,  16'h0001, 10'd0, 11'd0, 16'd0);
        send_cmd(OP_VOLUME, 16'h0000, 10'd0, 11'd0, 16'hFFFF);
        send_cmd(OP_VOLUME, 16'h0000, 10'd0, 11'd0, 16'd0);
        send_cmd(OP_PLAY,   16'h1234, 10'd5, 11'd0, 16'd0);
        send_cmd(OP_PLAY,   16'hFFFF, 10'h3FF, 11'h7FF, 16'hFFFF);
        send_cmd(OP_PREV,   16'h0000, 10'd0, 11'd0, 16'd0);
        send_cmd(OP_NEXT,   16'h0000, 10'd0, 11'd0, 16'd0);
        send_cmd(OP_EOT,    16'h0000, 10'd0, 11'd0, 16'd0);
        send_cmd(OP_PREV,   16'h0000, 10'd0, 11'd0, 16'd0);
        send_cmd(OP_PAUSE,  16'h0000, 10'd0, 11'd0, 16'd0);
        send_cmd(OP_PAUSE,  16'h0000, 10'd0, 11'd0, 16'd0);
        send_cmd(OP_TOGGLE, 16'h0000, 10'd0, 11'd0, 16'd0);
        send_cmd(OP_TOGGLE, 16'h0000, 10'd0, 11'd0, 16'd0);
        send_cmd(OP_STOP,   16'h0000, 10'd0, 11'd0, 16'd0);
        send_cmd(OP_TOGGLE, 16'h0000, 10'd0, 11'd0, 16'd0);
        send_cmd(OP_PLAY,   16'h00AA, 10'd700, 11'd1, 16'd0);
        send_cmd(OP_NEXT,   16'h0000, 10'd0, 11'd0, 16'd0);
        send_cmd(OP_PLAY,   16'h5555, 10'd1022, 11'd3, 16'd0);
        send_cmd(OP_NEXT,   16'h0000, 10'd0, 11'd0, 16'd0);
        send_cmd(OP_NEXT,   16'h0000, 10'd0, 11'd0, 16'd0);
        send_cmd(OP_NEXT,   16'h0000, 10'd0, 11'd0, 16'd0);
        random_cmds(10);
        wait_drained();

        // Random phases, each under its own register setting and idling mix.
        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0: set_regs(8'd255, 8'd0, 32'd1);
                1: set_regs(8'd0, 8'd255, 32'hFFFF_FFFF);
                2: set_regs(8'd21, 8'd12, 32'd0);
                default: set_regs(VOL_W'($urandom_range(255)), VOL_W'($urandom_range(255)),
                                  $urandom);
            endcase
            send_idle_pct  = (phase == 1 || phase == 3) ? ((phase == 1) ? 53 : 10) : 0;
            recv_stall_pct = (phase == 2 || phase == 3) ? ((phase == 2) ? 53 : 10) : 0;
            random_cmds(9);
            // Hold the next command back until all status has come back.
            if (phase == 1)
            begin
                s_tvalid <= 1'b0;
                @(posedge clk);
                while (pending != 0)
                    @(posedge clk);
            end
            random_cmds(9);
            wait_drained();
        end

        repeat (100) @(posedge clk);
        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
